/* sv/tlpt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpt_pkg
// Shared types and constants for the two-level page table translator.
// ----------------------------------------------------------------------------
package tlpt_pkg;

  typedef enum logic [1:0] {
    OP_MAP       = 2'd0,
    OP_UNMAP     = 2'd1,
    OP_TRANSLATE = 2'd2
  } op_e;

  localparam int unsigned VaWidth         = 32;
  localparam int unsigned FlagWidth       = 12;
  localparam int unsigned PageShift       = 12;
  localparam int unsigned DirShift        = 22;
  localparam int unsigned IndexWidth      = 10;
  localparam int unsigned EntriesPerTable = 1024;
  localparam int unsigned FrameWidth      = VaWidth - PageShift;

  localparam logic [FlagWidth-1:0] FlagsPresentWritable = 12'h003;

  // Item held between the memory read and the output register
  typedef struct packed {
    logic                 valid;
    op_e                  op;
    logic                 slot_present;
    logic [PageShift-1:0] offset;
  } stage_t;

endpackage

/* sv/two_level_page_table_translate.sv */
`timescale 1ns / 1ps
// A result beat passes the stage register and then the output register after its
// input beat is accepted.
// Throughput: one item per cycle while in_stall_o is low; each item reads the
// single-port entry memory at one address, a map or unmap of a present slot also
// writes it there, and writes commit at the accept edge. Reset: after rst_ni
// releases, a sweep loads the identity map into every entry, during which in_stall_o stays high.
// ----------------------------------------------------------------------------
// two_level_page_table_translate
// Page table store with map, unmap and translate operations on 4 KiB pages.
// ----------------------------------------------------------------------------
module two_level_page_table_translate #(
  parameter int unsigned TABLE_COUNT = 4
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                operation_i,
  input  logic [31:0]               virtual_address_i,
  input  logic [31:0]               frame_address_i,
  input  logic [11:0]               entry_flags_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [31:0]               result_address_o,
  output logic                      hit_o
);
  import tlpt_pkg::*;

  localparam int unsigned DirW  = (TABLE_COUNT > 1) ? $clog2(TABLE_COUNT) : 1;
  localparam int unsigned AddrW = DirW + IndexWidth;
  localparam int unsigned Depth = TABLE_COUNT * EntriesPerTable;

  logic [VaWidth-1:0] mem [Depth];

  logic             sweep_q, sweep_d;
  logic [AddrW-1:0] sweep_cnt_q, sweep_cnt_d;

  stage_t             s1_q, s1_d;
  logic [VaWidth-1:0] rd_q;
  logic               out_valid_q, out_valid_d;
  logic [VaWidth-1:0] out_addr_q, out_addr_d;
  logic               out_hit_q, out_hit_d;

  logic                  accept;
  logic                  s1_advance;
  logic [IndexWidth-1:0] dir_idx, tbl_idx;
  logic                  slot_present;
  logic [AddrW-1:0]      mem_addr;
  logic                  mem_we;
  logic [VaWidth-1:0]    mem_wdata;
  op_e                   op_in;

  assign op_in   = op_e'(operation_i);
  assign dir_idx = virtual_address_i[DirShift +: IndexWidth];
  assign tbl_idx = virtual_address_i[PageShift +: IndexWidth];
  assign slot_present = ({1'b0, dir_idx} < (IndexWidth + 1)'(TABLE_COUNT));

  assign s1_advance = !out_valid_q || !out_stall_i;
  assign in_stall_o = sweep_q || (s1_q.valid && !s1_advance);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    sweep_d     = sweep_q;
    sweep_cnt_d = sweep_cnt_q;
    mem_we      = 1'b0;
    mem_addr    = {dir_idx[DirW-1:0], tbl_idx};
    mem_wdata   = '0;
    if (sweep_q) begin
      mem_we    = 1'b1;
      mem_addr  = sweep_cnt_q;
      mem_wdata = {FrameWidth'(sweep_cnt_q), FlagsPresentWritable};
      if (sweep_cnt_q == AddrW'(Depth - 1)) begin
        sweep_d = 1'b0;
      end else begin
        sweep_cnt_d = sweep_cnt_q + 1'b1;
      end
    end else if (accept && slot_present) begin
      case (op_in)
        OP_MAP: begin
          mem_we    = 1'b1;
          mem_wdata = {frame_address_i[VaWidth-1:PageShift], entry_flags_i};
        end
        OP_UNMAP: begin
          mem_we    = 1'b1;
          mem_wdata = '0;
        end
        default: begin
          mem_we = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    // Capture the read only on an accepted beat; a stalled lookup keeps its data
    if (accept) begin
      rd_q <= mem[mem_addr];
    end
  end

  always_comb begin
    s1_d = s1_q;
    if (accept) begin
      s1_d.valid        = 1'b1;
      s1_d.op           = op_in;
      s1_d.slot_present = slot_present;
      s1_d.offset       = virtual_address_i[PageShift-1:0];
    end else if (s1_advance) begin
      s1_d.valid = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_addr_d  = out_addr_q;
    out_hit_d   = out_hit_q;
    if (s1_advance) begin
      out_valid_d = s1_q.valid;
      out_addr_d  = '0;
      out_hit_d   = 1'b0;
      case (s1_q.op)
        OP_MAP, OP_UNMAP: begin
          out_hit_d = s1_q.slot_present;
        end
        OP_TRANSLATE: begin
          if (s1_q.slot_present && rd_q[0]) begin
            out_hit_d  = 1'b1;
            out_addr_d = {rd_q[VaWidth-1:PageShift], s1_q.offset};
          end
        end
        default: begin
          out_hit_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q     <= 1'b1;
      sweep_cnt_q <= '0;
      s1_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      sweep_q     <= sweep_d;
      sweep_cnt_q <= sweep_cnt_d;
      s1_q        <= s1_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold payload registers without reset
  always_ff @(posedge clk_i) begin
    out_addr_q <= out_addr_d;
    out_hit_q  <= out_hit_d;
  end

  assign out_valid_o      = out_valid_q;
  assign result_address_o = out_addr_q;
  assign hit_o            = out_hit_q;

endmodule

/* sv/tlpt_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpt_checker
// Port-level checks for the page table translator, bound to the top level.
// ----------------------------------------------------------------------------
module tlpt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [1:0]  operation_i,
  input logic [31:0] virtual_address_i,
  input logic [31:0] frame_address_i,
  input logic [11:0] entry_flags_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] result_address_o,
  input logic        hit_o
);
  import tlpt_pkg::*;

  // Stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(result_address_o) && $stable(hit_o))
    else $error("stalled result beat changed");

  // A miss never carries an address
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> result_address_o == 32'd0)
    else $error("result address nonzero without hit");

  // The table load sweep blocks input right after reset
  a_sweep_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> in_stall_o)
    else $error("input not stalled during reset sweep");

  // A result beat only appears for an accepted input beat
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result beat without accepted input beat");

endmodule

bind two_level_page_table_translate tlpt_checker u_tlpt_checker (.*);

/* dv/page_table_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_table_checker
// Watches both channels of the page table translator. It keeps a shadow copy
// of the entry store, computes the result of every accepted request beat,
// and compares each result beat with the oldest outstanding lookup.
// ----------------------------------------------------------------------------
module page_table_checker #(
  parameter int unsigned TableCount = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  operation_i,
  input  logic [31:0] virtual_address_i,
  input  logic [31:0] frame_address_i,
  input  logic [11:0] entry_flags_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [31:0] result_address_i,
  input  logic        hit_i,
  output int unsigned fail_count_o,
  output int unsigned pending_count_o
);
  import tlpt_pkg::*;

  localparam int unsigned StoreDepth = TableCount * EntriesPerTable;
  localparam int unsigned PresentBit = 0;
  localparam int unsigned ReportLimit = 10;

  typedef struct packed {
    logic [31:0] address;
    logic        hit;
  } lookup_t;

  logic [31:0] shadow_entries [StoreDepth];
  lookup_t     expected_lookups [$];
  int unsigned failures = 0;

  assign fail_count_o = failures;

  // Apply one request to the shadow store and return the result it produces.
  function automatic lookup_t walk_table(input logic [1:0] op, input logic [31:0] va,
                                         input logic [31:0] frame,
                                         input logic [11:0] flags);
    lookup_t     res;
    int unsigned dir;
    int unsigned idx;
    logic        mapped;
    res    = '0;
    dir    = 32'(va[31:DirShift]);
    idx    = dir * EntriesPerTable + 32'(va[DirShift-1:PageShift]);
    mapped = (dir < TableCount);
    case (op)
      OP_MAP: begin
        if (mapped) begin
          shadow_entries[idx] = {frame[31:PageShift], flags};
          res.hit = 1'b1;
        end
      end
      OP_UNMAP: begin
        if (mapped) begin
          shadow_entries[idx] = '0;
          res.hit = 1'b1;
        end
      end
      OP_TRANSLATE: begin
        if (mapped && shadow_entries[idx][PresentBit]) begin
          res.address = {shadow_entries[idx][31:PageShift], va[PageShift-1:0]};
          res.hit     = 1'b1;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic void note_failure(input string what, input logic [31:0] want,
                                       input logic [31:0] got);
    if (failures < ReportLimit)
      $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, want, got);
    failures++;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    lookup_t want;
    if (!rst_ni) begin
      // identity map, every entry present and writable
      for (int unsigned n = 0; n < StoreDepth; n++)
        shadow_entries[n] = {n[FrameWidth-1:0], FlagsPresentWritable};
      expected_lookups.delete();
      pending_count_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i)
        expected_lookups.push_back(walk_table(operation_i, virtual_address_i,
                                              frame_address_i, entry_flags_i));
      if (out_valid_i && !out_stall_i) begin
        if (expected_lookups.size() == 0) begin
          if (failures < ReportLimit)
            $display("%0t: result beat with nothing outstanding: address %h hit %b",
                     $realtime, result_address_i, hit_i);
          failures++;
        end else begin
          want = expected_lookups.pop_front();
          if (result_address_i !== want.address)
            note_failure("result_address", want.address, result_address_i);
          if (hit_i !== want.hit)
            note_failure("hit", 32'(want.hit), 32'(hit_i));
        end
      end
      pending_count_o <= expected_lookups.size();
    end
  end

endmodule

/* dv/two_level_page_table_translate_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_level_page_table_translate_test
// Drives map, unmap and translate requests into the page table translator:
// a directed set over the corner cases, then random traffic biased toward
// present directory slots and recently mapped or unmapped pages, under several idle and
// stall mixes. The checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module two_level_page_table_translate_test;
  import tlpt_pkg::*;

  localparam int unsigned TableCount     = 4;
  localparam logic [1:0]  OpReserved     = 2'd3;
  localparam int unsigned QuietLimit     = 20000;
  localparam int unsigned DrainCycles    = 8;
  localparam int unsigned RandomPerPhase = 307;
  localparam int unsigned PoolDepth      = 32;

  logic        clk_i             = 1'b0;
  logic        rst_ni            = 1'b0;
  logic        in_valid_i        = 1'b0;
  logic        in_stall_o;
  logic [1:0]  operation_i       = '0;
  logic [31:0] virtual_address_i = '0;
  logic [31:0] frame_address_i   = '0;
  logic [11:0] entry_flags_i     = '0;
  logic        out_valid_o;
  logic        out_stall_i       = 1'b0;
  logic [31:0] result_address_o;
  logic        hit_o;

  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned idle_pct    = 0;
  int unsigned stall_pct   = 0;
  int unsigned quiet_cycles = 0;
  logic [19:0] recent_pages [$];

  two_level_page_table_translate #(
    .TABLE_COUNT(TableCount)
  ) uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .operation_i      (operation_i),
    .virtual_address_i(virtual_address_i),
    .frame_address_i  (frame_address_i),
    .entry_flags_i    (entry_flags_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .result_address_o (result_address_o),
    .hit_o            (hit_o)
  );

  page_table_checker #(
    .TableCount(TableCount)
  ) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .operation_i      (operation_i),
    .virtual_address_i(virtual_address_i),
    .frame_address_i  (frame_address_i),
    .entry_flags_i    (entry_flags_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .result_address_i (result_address_o),
    .hit_i            (hit_o),
    .fail_count_o     (fail_count),
    .pending_count_o  (pending_count)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  // End the run when neither channel moves a beat for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_request(input logic [1:0] op, input logic [31:0] va,
                              input logic [31:0] frame, input logic [11:0] flags);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    operation_i       <= op;
    virtual_address_i <= va;
    frame_address_i   <= frame;
    entry_flags_i     <= flags;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Hold the sender off until every outstanding result has come back.
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
  endtask

  task automatic send_random_request();
    logic [1:0]  op;
    logic [31:0] va;
    logic [31:0] frame;
    logic [11:0] flags;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 40)      op = OP_TRANSLATE;
    else if (pick < 72) op = OP_MAP;
    else if (pick < 92) op = OP_UNMAP;
    else                op = OpReserved;
    pick = $urandom_range(0, 99);
    if (pick < 10)
      va = $urandom();
    else if (pick < 60 && recent_pages.size() > 0)
      va = {recent_pages[$urandom_range(0, recent_pages.size() - 1)], 12'($urandom())};
    else
      va = {10'($urandom_range(0, TableCount - 1)), 10'($urandom()), 12'($urandom())};
    frame = $urandom();
    flags = 12'($urandom());
    if ($urandom_range(0, 99) < 75) flags[0] = 1'b1;
    if ((op == OP_MAP || op == OP_UNMAP) && va[31:DirShift] < TableCount) begin
      recent_pages.push_back(va[31:PageShift]);
      if (recent_pages.size() > PoolDepth) void'(recent_pages.pop_front());
    end
    send_request(op, va, frame, flags);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // corners: reset identity map, absent slots, flag handling, unknown op
    send_request(OP_TRANSLATE, 32'h0000_0000, 32'h0, 12'h000);
    send_request(OP_TRANSLATE, 32'hFFFF_FFFF, 32'h0, 12'h000);
    send_request(OP_TRANSLATE, 32'h00FF_FFFF, 32'h0, 12'h000);
    send_request(OP_TRANSLATE, 32'h0100_0000, 32'h0, 12'h000);
    send_request(OP_MAP,       32'h00FF_F123, 32'hFFFF_FFFF, 12'hFFF);
    send_request(OP_TRANSLATE, 32'h00FF_FABC, 32'h0, 12'h000);
    send_request(OP_MAP,       32'h0000_0000, 32'h0000_0000, 12'h000);
    send_request(OP_TRANSLATE, 32'h0000_0FFF, 32'h0, 12'h000);
    send_request(OP_MAP,       32'h0000_1000, 32'hABCD_E000, 12'h001);
    send_request(OP_TRANSLATE, 32'h0000_1555, 32'h0, 12'h000);
    send_request(OP_UNMAP,     32'h0000_1000, 32'hFFFF_FFFF, 12'hFFF);
    send_request(OP_TRANSLATE, 32'h0000_1000, 32'h0, 12'h000);
    send_request(OP_MAP,       32'hFFC0_0000, 32'h1234_5FFF, 12'h003);
    send_request(OP_UNMAP,     32'h0100_0000, 32'h0, 12'h000);
    send_request(OP_TRANSLATE, 32'hFFC0_0000, 32'h0, 12'h000);
    send_request(OpReserved,   32'h0000_2000, 32'hFFFF_FFFF, 12'hFFF);
    send_request(OP_TRANSLATE, 32'h0000_2000, 32'h0, 12'h000);
    send_request(OP_MAP,       32'h0040_2000, 32'h0000_0FFF, 12'h002);
    send_request(OP_TRANSLATE, 32'h0040_2000, 32'h0, 12'h000);
    send_request(OP_MAP,       32'h0040_2000, 32'h5A5A_5000, 12'h7FF);
    send_request(OP_TRANSLATE, 32'h0040_2FFF, 32'h0, 12'h000);
    send_request(OP_UNMAP,     32'hFFFF_FFFF, 32'h0, 12'h000);
    send_request(OpReserved,   32'hFFFF_FFFF, 32'h0, 12'h000);

    for (int phase = 0; phase < 4; phase++) begin
      wait_for_results();
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 88; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 88; end
        default: begin idle_pct = 16; stall_pct = 16; end
      endcase
      for (int n = 0; n < RandomPerPhase; n++) begin
        if (phase == 1 && n == RandomPerPhase / 2) wait_for_results();
        send_random_request();
      end
    end

    wait_for_results();
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0 && pending_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
